### hdl/connected_component_labeler_core_defines.svh
// Assertion macros for the connected component labeler.
`ifndef CONNECTED_COMPONENT_LABELER_CORE_DEFINES_SVH
`define CONNECTED_COMPONENT_LABELER_CORE_DEFINES_SVH

// Check a consequence in the same cycle.
`define CCL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the next cycle.
`define CCL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/ccl_pkg.sv
// Types and constants shared by the connected component labeler.
package ccl_pkg;

    localparam int LABEL_W    = 12;
    localparam int COORD_W    = 6;
    localparam int SIDE_REG_W = 7;
    localparam int SIDE_EXT_W = 8;
    localparam int CFG_IDX_W  = 2;

    localparam logic [SIDE_REG_W-1:0] SIDE_RESET      = 7'd64;
    localparam logic [CFG_IDX_W-1:0]  CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0]  CFG_GRID_HEIGHT = 2'd1;
    localparam logic                  REQ_WRITE       = 1'b0;
    localparam logic                  REQ_QUERY       = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [COORD_W-1:0] cell_col;
        logic [COORD_W-1:0] cell_row;
        logic               occupied;
    } t_ccl_in;

    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic [LABEL_W-1:0] component_count;
        logic               bounds_error;
    } t_ccl_out;

    typedef enum logic [3:0] {
        S_RST_CLR,
        S_IDLE,
        S_LAB_CLR,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_POP_RD,
        S_POP_DATA,
        S_NB_RD,
        S_NB_CHK,
        S_Q_RD,
        S_Q_OUT
    } t_ccl_state;

endpackage

### hdl/ccl_ram.sv
// Simple dual-port RAM with registered read data.
module ccl_ram #(
    parameter int W  = 12,
    parameter int AW = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [0:(1<<AW)-1];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/connected_component_labeler_core.sv
// Connected component labeler: 4-connected flood fill over a cell grid held in RAM.
// A write is taken in the idle state; a query with fresh labels reads the label RAM and
// registers its result word. A query after a change first relabels: it clears the whole
// label RAM, then scans the cells of the grid and floods each new component through its
// neighbours, paced by the single read port of the cell and label RAMs. Throughput is one item at a time.
// Synchronous reset sweeps the whole cell RAM to zero before input is taken.
`include "connected_component_labeler_core_defines.svh"

module connected_component_labeler_core #(
    parameter int MAX_SIDE = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  ccl_pkg::t_ccl_in              i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output ccl_pkg::t_ccl_out             o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ccl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ccl_pkg::SIDE_REG_W-1:0] i_cfg_data
);

    localparam int CW    = $clog2(MAX_SIDE);
    localparam int AW    = 2 * CW;
    localparam int DEPTH = 1 << AW;
    localparam int SPW   = AW + 1;
    localparam int LMW   = (AW + 1 > ccl_pkg::LABEL_W) ? AW + 1 : ccl_pkg::LABEL_W;
    localparam int EW    = ccl_pkg::SIDE_EXT_W;

    ccl_pkg::t_ccl_state r_state, n_state;

    logic [ccl_pkg::SIDE_REG_W-1:0] r_w, r_h;
    logic            r_stale;
    logic [LMW-1:0]  r_total;
    logic [AW-1:0]   r_clr;
    logic [CW-1:0]   r_sc_col, r_sc_row;
    logic [CW-1:0]   r_cur_col, r_cur_row;
    logic [1:0]      r_nb;
    logic [AW-1:0]   r_nb_addr;
    logic [SPW-1:0]  r_sp;
    logic [AW-1:0]   r_q_addr;
    logic            r_q_inside;
    logic            r_out_valid;
    ccl_pkg::t_ccl_out r_out;

    logic [EW-1:0]   w_eff, h_eff;
    logic            grid_empty;
    logic            in_acc, cfg_acc, out_free;
    logic            in_wr, cfg_side;
    logic [EW-1:0]   in_col8, in_row8;
    logic            in_inside;
    logic [AW-1:0]   in_addr, scan_addr, nb_addr;
    logic            more_col, more_row, scan_last;
    logic            clr_last;
    logic            nb_ok;
    logic [CW-1:0]   nb_col, nb_row;
    logic            cell_free;
    logic [SPW-1:0]  sp_dec;

    logic            pix_we, pix_wdata, pix_rd;
    logic [AW-1:0]   pix_waddr;
    logic            lab_we;
    logic [AW-1:0]   lab_waddr;
    logic [LMW-1:0]  lab_wdata, lab_rd;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic            stk_we, stk_re;
    logic [AW-1:0]   stk_waddr, stk_wdata, stk_raddr, stk_rd;

    // Effective grid sides, clipped to the store size.
    assign w_eff = ({1'b0, r_w} > EW'(MAX_SIDE)) ? EW'(MAX_SIDE) : {1'b0, r_w};
    assign h_eff = ({1'b0, r_h} > EW'(MAX_SIDE)) ? EW'(MAX_SIDE) : {1'b0, r_h};
    assign grid_empty = (w_eff == '0) || (h_eff == '0);

    assign o_in_stall  = (r_state != ccl_pkg::S_IDLE);
    assign o_cfg_ready = (r_state == ccl_pkg::S_IDLE) || (r_state == ccl_pkg::S_RST_CLR);
    assign in_acc   = i_in_valid && !o_in_stall;
    assign cfg_acc  = i_cfg_valid && o_cfg_ready;
    assign out_free = !r_out_valid || !i_out_stall;

    assign in_col8   = EW'(i_in_data.cell_col);
    assign in_row8   = EW'(i_in_data.cell_row);
    assign in_inside = (in_col8 < w_eff) && (in_row8 < h_eff);
    assign in_addr   = {in_row8[CW-1:0], in_col8[CW-1:0]};
    assign in_wr     = in_acc && (i_in_data.req_type == ccl_pkg::REQ_WRITE) && in_inside;
    assign cfg_side  = cfg_acc && ((i_cfg_index == ccl_pkg::CFG_GRID_WIDTH)
                                   || (i_cfg_index == ccl_pkg::CFG_GRID_HEIGHT));

    assign scan_addr = {r_sc_row, r_sc_col};
    assign more_col  = (EW'(r_sc_col) + EW'(1)) < w_eff;
    assign more_row  = (EW'(r_sc_row) + EW'(1)) < h_eff;
    assign scan_last = !more_col && !more_row;
    assign clr_last  = (r_clr == {AW{1'b1}});
    assign cell_free = pix_rd && (lab_rd == '0);
    assign sp_dec    = r_sp - SPW'(1);

    // Neighbour order: right, left, below, above.
    always_comb begin
        nb_ok  = 1'b0;
        nb_col = r_cur_col;
        nb_row = r_cur_row;
        case (r_nb)
            2'd0: begin
                nb_ok  = (EW'(r_cur_col) + EW'(1)) < w_eff;
                nb_col = r_cur_col + CW'(1);
            end
            2'd1: begin
                nb_ok  = (r_cur_col != '0);
                nb_col = r_cur_col - CW'(1);
            end
            2'd2: begin
                nb_ok  = (EW'(r_cur_row) + EW'(1)) < h_eff;
                nb_row = r_cur_row + CW'(1);
            end
            default: begin
                nb_ok  = (r_cur_row != '0);
                nb_row = r_cur_row - CW'(1);
            end
        endcase
    end
    assign nb_addr = {nb_row, nb_col};

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ccl_pkg::S_RST_CLR: begin
                if (clr_last) n_state = ccl_pkg::S_IDLE;
            end
            ccl_pkg::S_IDLE: begin
                if (in_acc && (i_in_data.req_type == ccl_pkg::REQ_QUERY)) begin
                    n_state = r_stale ? ccl_pkg::S_LAB_CLR : ccl_pkg::S_Q_RD;
                end
            end
            ccl_pkg::S_LAB_CLR: begin
                if (clr_last) begin
                    n_state = grid_empty ? ccl_pkg::S_Q_RD : ccl_pkg::S_SCAN_RD;
                end
            end
            ccl_pkg::S_SCAN_RD: n_state = ccl_pkg::S_SCAN_CHK;
            ccl_pkg::S_SCAN_CHK: begin
                if (cell_free)      n_state = ccl_pkg::S_POP_RD;
                else if (scan_last) n_state = ccl_pkg::S_Q_RD;
                else                n_state = ccl_pkg::S_SCAN_RD;
            end
            ccl_pkg::S_POP_RD: begin
                if (r_sp != '0)     n_state = ccl_pkg::S_POP_DATA;
                else if (scan_last) n_state = ccl_pkg::S_Q_RD;
                else                n_state = ccl_pkg::S_SCAN_RD;
            end
            ccl_pkg::S_POP_DATA: n_state = ccl_pkg::S_NB_RD;
            ccl_pkg::S_NB_RD: begin
                if (nb_ok)             n_state = ccl_pkg::S_NB_CHK;
                else if (r_nb == 2'd3) n_state = ccl_pkg::S_POP_RD;
            end
            ccl_pkg::S_NB_CHK: begin
                n_state = (r_nb == 2'd3) ? ccl_pkg::S_POP_RD : ccl_pkg::S_NB_RD;
            end
            ccl_pkg::S_Q_RD: n_state = ccl_pkg::S_Q_OUT;
            ccl_pkg::S_Q_OUT: begin
                if (out_free) n_state = ccl_pkg::S_IDLE;
            end
            default: n_state = ccl_pkg::S_IDLE;
        endcase
    end

    // Memory port control.
    always_comb begin
        pix_we    = 1'b0;
        pix_waddr = r_clr;
        pix_wdata = 1'b0;
        lab_we    = 1'b0;
        lab_waddr = r_clr;
        lab_wdata = '0;
        rd_en     = 1'b0;
        rd_addr   = scan_addr;
        stk_we    = 1'b0;
        stk_waddr = r_sp[AW-1:0];
        stk_wdata = scan_addr;
        stk_re    = 1'b0;
        stk_raddr = sp_dec[AW-1:0];
        unique case (r_state)
            ccl_pkg::S_RST_CLR: pix_we = 1'b1;
            ccl_pkg::S_IDLE: begin
                if (in_acc && (i_in_data.req_type == ccl_pkg::REQ_WRITE) && in_inside) begin
                    pix_we    = 1'b1;
                    pix_waddr = in_addr;
                    pix_wdata = i_in_data.occupied;
                end
            end
            ccl_pkg::S_LAB_CLR: lab_we = 1'b1;
            ccl_pkg::S_SCAN_RD: rd_en = 1'b1;
            ccl_pkg::S_SCAN_CHK: begin
                if (cell_free) begin
                    lab_we    = 1'b1;
                    lab_waddr = scan_addr;
                    lab_wdata = r_total + LMW'(1);
                    stk_we    = 1'b1;
                end
            end
            ccl_pkg::S_POP_RD: stk_re = (r_sp != '0);
            ccl_pkg::S_POP_DATA: ;
            ccl_pkg::S_NB_RD: begin
                rd_en   = nb_ok;
                rd_addr = nb_addr;
            end
            ccl_pkg::S_NB_CHK: begin
                if (cell_free) begin
                    lab_we    = 1'b1;
                    lab_waddr = r_nb_addr;
                    lab_wdata = r_total;
                    stk_we    = 1'b1;
                    stk_wdata = r_nb_addr;
                end
            end
            ccl_pkg::S_Q_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_q_addr;
            end
            ccl_pkg::S_Q_OUT: ;
            default: ;
        endcase
    end

    ccl_ram #(.W(1), .AW(AW)) u_pix (
        .i_clk   (i_clk),
        .i_we    (pix_we),
        .i_waddr (pix_waddr),
        .i_wdata (pix_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (pix_rd)
    );

    ccl_ram #(.W(LMW), .AW(AW)) u_lab (
        .i_clk   (i_clk),
        .i_we    (lab_we),
        .i_waddr (lab_waddr),
        .i_wdata (lab_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (lab_rd)
    );

    ccl_ram #(.W(AW), .AW(AW)) u_stk (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rd)
    );

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ccl_pkg::S_RST_CLR;
            r_w         <= ccl_pkg::SIDE_RESET;
            r_h         <= ccl_pkg::SIDE_RESET;
            r_stale     <= 1'b1;
            r_total     <= '0;
            r_clr       <= '0;
            r_sc_col    <= '0;
            r_sc_row    <= '0;
            r_nb        <= '0;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            // Hold the result word while stalled, load a new one from the query state.
            r_out_valid <= ((r_state == ccl_pkg::S_Q_OUT) && out_free)
                           || (r_out_valid && i_out_stall);
            if (cfg_acc) begin
                case (i_cfg_index)
                    ccl_pkg::CFG_GRID_WIDTH:  r_w <= i_cfg_data;
                    ccl_pkg::CFG_GRID_HEIGHT: r_h <= i_cfg_data;
                    default: ;
                endcase
            end
            if (cfg_side || in_wr) begin
                r_stale <= 1'b1;
            end else if (r_state == ccl_pkg::S_Q_RD) begin
                r_stale <= 1'b0;
            end
            case (r_state)
                ccl_pkg::S_RST_CLR: r_clr <= r_clr + AW'(1);
                ccl_pkg::S_IDLE: begin
                    if (in_acc && (i_in_data.req_type == ccl_pkg::REQ_QUERY) && r_stale) begin
                        r_total <= '0;
                    end
                end
                ccl_pkg::S_LAB_CLR: begin
                    r_clr    <= r_clr + AW'(1);
                    r_sc_col <= '0;
                    r_sc_row <= '0;
                    r_sp     <= '0;
                end
                ccl_pkg::S_SCAN_CHK, ccl_pkg::S_POP_RD: begin
                    if ((r_state == ccl_pkg::S_SCAN_CHK) && cell_free) begin
                        r_total <= r_total + LMW'(1);
                        r_sp    <= SPW'(1);
                    end else if ((r_state == ccl_pkg::S_POP_RD) && (r_sp != '0)) begin
                        r_sp <= sp_dec;
                    end else if (more_col) begin
                        r_sc_col <= r_sc_col + CW'(1);
                    end else if (more_row) begin
                        r_sc_col <= '0;
                        r_sc_row <= r_sc_row + CW'(1);
                    end
                end
                ccl_pkg::S_POP_DATA: r_nb <= '0;
                ccl_pkg::S_NB_RD: begin
                    if (!nb_ok) r_nb <= r_nb + 2'd1;
                end
                ccl_pkg::S_NB_CHK: begin
                    if (cell_free) r_sp <= r_sp + SPW'(1);
                    r_nb <= r_nb + 2'd1;
                end
                default: ;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if ((r_state == ccl_pkg::S_IDLE) && in_acc) begin
            r_q_addr   <= in_addr;
            r_q_inside <= in_inside;
        end
        if (r_state == ccl_pkg::S_POP_DATA) begin
            r_cur_col <= stk_rd[CW-1:0];
            r_cur_row <= stk_rd[AW-1:CW];
        end
        if ((r_state == ccl_pkg::S_NB_RD) && nb_ok) begin
            r_nb_addr <= nb_addr;
        end
        if ((r_state == ccl_pkg::S_Q_OUT) && out_free) begin
            r_out.label           <= r_q_inside ? lab_rd[ccl_pkg::LABEL_W-1:0] : '0;
            r_out.component_count <= r_total[ccl_pkg::LABEL_W-1:0];
            r_out.bounds_error    <= !r_q_inside;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `CCL_ASSERT_NOW(a_sp_bound, 1'b1, r_sp <= SPW'(DEPTH), "fill stack pointer beyond depth")
    `CCL_ASSERT_NOW(a_err_label, r_out_valid && r_out.bounds_error, r_out.label == '0, "bounds error with label")
    `CCL_ASSERT_NEXT(a_out_hold, (r_state == ccl_pkg::S_Q_OUT) && r_out_valid && i_out_stall, r_state == ccl_pkg::S_Q_OUT, "result word overwritten")
    `CCL_ASSERT_NEXT(a_fresh, r_state == ccl_pkg::S_Q_RD, !r_stale, "labels stale at result")

endmodule

### sim/tb_connected_component_labeler_core.sv
// Self-checking testbench for the connected component labeler core.
`timescale 1ns / 1ps

module tb_connected_component_labeler_core;

    localparam int SIDE       = 64;
    localparam int CELLS      = SIDE * SIDE;
    localparam int HANG_LIMIT = 250000;
    localparam int SETTLE     = 20;
    localparam int PHASE_WORDS = 140;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    ccl_pkg::t_ccl_in               in_data = '0;
    logic                           out_stall = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic [ccl_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ccl_pkg::SIDE_REG_W-1:0] cfg_data = '0;
    wire                            o_in_stall;
    wire                            o_out_valid;
    ccl_pkg::t_ccl_out              o_out_data;
    wire                            o_cfg_ready;

    connected_component_labeler_core #(.MAX_SIDE(SIDE)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the grid and its labelling
    bit                             cell_map [CELLS];
    logic [ccl_pkg::LABEL_W-1:0]    label_grid [CELLS];
    int                             fill_stk [$];
    bit                             labels_stale = 1'b1;
    int                             comp_total = 0;
    logic [ccl_pkg::SIDE_REG_W-1:0] width_reg = ccl_pkg::SIDE_RESET;
    logic [ccl_pkg::SIDE_REG_W-1:0] height_reg = ccl_pkg::SIDE_RESET;

    ccl_pkg::t_ccl_in  pending_words [$];
    ccl_pkg::t_ccl_out label_expect [$];
    int       mismatches = 0;
    int       hang_cycles = 0;
    bit       in_taken = 1'b0;
    bit       quiet = 1'b0;
    int       in_gap = 0;
    int       out_gap = 0;
    int       counted = 0;

    function automatic int eff_side(input logic [ccl_pkg::SIDE_REG_W-1:0] v);
        return (v > SIDE) ? SIDE : int'(v);
    endfunction

    function automatic void mark_cell(input int c, input int r,
                                      input logic [ccl_pkg::LABEL_W-1:0] lab);
        int idx;
        idx = r * SIDE + c;
        if (!cell_map[idx] || label_grid[idx] != 0)
            return;
        label_grid[idx] = lab;
        fill_stk.push_back(idx);
    endfunction

    function automatic void relabel();
        int w, h, idx, cur, cc, cr;
        logic [ccl_pkg::LABEL_W-1:0] lab;
        w = eff_side(width_reg);
        h = eff_side(height_reg);
        foreach (label_grid[k]) label_grid[k] = '0;
        comp_total = 0;
        for (int r = 0; r < h; r++) begin
            for (int c = 0; c < w; c++) begin
                idx = r * SIDE + c;
                if (cell_map[idx] && label_grid[idx] == 0) begin
                    comp_total++;
                    lab = comp_total[ccl_pkg::LABEL_W-1:0];
                    mark_cell(c, r, lab);
                    while (fill_stk.size() > 0) begin
                        cur = fill_stk.pop_back();
                        cc = cur % SIDE;
                        cr = cur / SIDE;
                        if (cc + 1 < w) mark_cell(cc + 1, cr, lab);
                        if (cc > 0)     mark_cell(cc - 1, cr, lab);
                        if (cr + 1 < h) mark_cell(cc, cr + 1, lab);
                        if (cr > 0)     mark_cell(cc, cr - 1, lab);
                    end
                end
            end
        end
        labels_stale = 1'b0;
    endfunction

    function automatic void apply_word(input ccl_pkg::t_ccl_in w);
        bit                in_grid;
        ccl_pkg::t_ccl_out r;
        in_grid = w.cell_col < eff_side(width_reg) && w.cell_row < eff_side(height_reg);
        if (w.req_type == ccl_pkg::REQ_WRITE) begin
            if (in_grid) begin
                cell_map[w.cell_row * SIDE + w.cell_col] = w.occupied;
                labels_stale = 1'b1;
            end
        end else begin
            if (labels_stale)
                relabel();
            r.label = in_grid ? label_grid[w.cell_row * SIDE + w.cell_col] : '0;
            r.component_count = comp_total[ccl_pkg::LABEL_W-1:0];
            r.bounds_error = !in_grid;
            label_expect.push_back(r);
        end
    endfunction

    function automatic void apply_cfg(input logic [ccl_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [ccl_pkg::SIDE_REG_W-1:0] val);
        if (idx == ccl_pkg::CFG_GRID_WIDTH) begin
            width_reg = val;
            labels_stale = 1'b1;
        end else if (idx == ccl_pkg::CFG_GRID_HEIGHT) begin
            height_reg = val;
            labels_stale = 1'b1;
        end
    endfunction

    // Inputs change on the falling edge
    always @(negedge i_clk) begin
        logic nv;
        nv = in_valid;
        if (in_taken) begin
            nv = 1'b0;
            in_taken = 1'b0;
        end
        if (!nv) begin
            if (in_gap > 0) begin
                in_gap--;
            end else if (pending_words.size() > 0) begin
                if (!quiet && $urandom_range(0, 9) == 0) begin
                    in_gap = $urandom_range(1, 16);
                end else begin
                    in_data <= pending_words.pop_front();
                    nv = 1'b1;
                end
            end
        end
        in_valid <= nv;
        if (out_gap > 0) begin
            out_gap--;
            out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            out_gap = $urandom_range(1, 16) - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Sample on the rising edge: predict, check, watch for a hang
    always @(posedge i_clk) begin
        bit                moved;
        ccl_pkg::t_ccl_out want;
        moved = 1'b0;
        if (i_rst_n) begin
            if (in_valid && !o_in_stall) begin
                apply_word(in_data);
                in_taken = 1'b1;
                moved = 1'b1;
            end
            if (cfg_valid && o_cfg_ready) begin
                apply_cfg(cfg_index, cfg_data);
                moved = 1'b1;
            end
            if (o_out_valid && !out_stall) begin
                moved = 1'b1;
                if (label_expect.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: %p", o_out_data);
                end else begin
                    want = label_expect.pop_front();
                    if (o_out_data.label !== want.label
                            || o_out_data.component_count !== want.component_count
                            || o_out_data.bounds_error !== want.bounds_error) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected %p, got %p", want, o_out_data);
                    end
                end
            end
            hang_cycles = moved ? 0 : hang_cycles + 1;
            if (hang_cycles >= HANG_LIMIT) begin
                $display("connected_component_labeler_core regression: fail");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_words.size() > 0 || in_valid || label_expect.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [ccl_pkg::CFG_IDX_W-1:0] idx, input int val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[ccl_pkg::SIDE_REG_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_word(input logic kind, input int c, input int r, input bit occ);
        ccl_pkg::t_ccl_in w;
        w.req_type = kind;
        w.cell_col = c[ccl_pkg::COORD_W-1:0];
        w.cell_row = r[ccl_pkg::COORD_W-1:0];
        w.occupied = occ;
        pending_words.push_back(w);
    endtask

    // Pick a cell inside the grid in use, or outside it where that is possible
    task automatic pick_cell(input bit want_in, output int c, output int r, output bit in_grid);
        int w, h;
        w = eff_side(width_reg);
        h = eff_side(height_reg);
        if (w == 0 || h == 0 || (!want_in && (w < SIDE || h < SIDE))) begin
            c = $urandom_range(0, SIDE - 1);
            r = $urandom_range(0, SIDE - 1);
            if (w > 0 && h > 0) begin
                if (w < SIDE && (h == SIDE || $urandom_range(0, 1)))
                    c = $urandom_range(w, SIDE - 1);
                else
                    r = $urandom_range(h, SIDE - 1);
            end
        end else begin
            c = $urandom_range(0, w - 1);
            r = $urandom_range(0, h - 1);
        end
        in_grid = c < w && r < h;
    endtask

    task automatic random_phase(input int budget);
        int  c, r, n, done;
        bit  in_grid;
        done = 0;
        while (done < budget) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise: any mix of words anywhere
                repeat ($urandom_range(1, 10)) begin
                    pick_cell(1'($urandom_range(0, 1)), c, r, in_grid);
                    add_word(1'($urandom_range(0, 1)), c, r, 1'($urandom_range(0, 1)));
                    done++;
                end
            end else begin
                n = $urandom_range(1, 12);
                repeat (n) begin
                    pick_cell($urandom_range(0, 9) != 0, c, r, in_grid);
                    add_word(ccl_pkg::REQ_WRITE, c, r, $urandom_range(0, 9) < 6);
                    if (in_grid) done++;
                end
                n = $urandom_range(1, 8);
                repeat (n) begin
                    pick_cell($urandom_range(0, 9) != 0, c, r, in_grid);
                    add_word(ccl_pkg::REQ_QUERY, c, r, 1'($urandom_range(0, 1)));
                    done++;
                end
            end
            wait_drained();
        end
    endtask

    initial begin
        int w, h;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // full grid: empty query, corners, neighbours, clearing a cell
        add_word(ccl_pkg::REQ_QUERY, 0, 0, 1'b0);
        add_word(ccl_pkg::REQ_WRITE, 0, 0, 1'b1);
        add_word(ccl_pkg::REQ_WRITE, 63, 63, 1'b1);
        add_word(ccl_pkg::REQ_WRITE, 63, 0, 1'b1);
        add_word(ccl_pkg::REQ_WRITE, 0, 63, 1'b1);
        add_word(ccl_pkg::REQ_WRITE, 1, 0, 1'b1);
        add_word(ccl_pkg::REQ_QUERY, 0, 0, 1'b1);
        add_word(ccl_pkg::REQ_QUERY, 63, 63, 1'b0);
        add_word(ccl_pkg::REQ_QUERY, 63, 0, 1'b0);
        add_word(ccl_pkg::REQ_QUERY, 0, 63, 1'b0);
        add_word(ccl_pkg::REQ_QUERY, 1, 0, 1'b0);
        add_word(ccl_pkg::REQ_WRITE, 0, 0, 1'b0);
        add_word(ccl_pkg::REQ_QUERY, 1, 0, 1'b0);
        add_word(ccl_pkg::REQ_QUERY, 0, 0, 1'b0);
        wait_drained();

        // small grid: write outside is dropped, query outside flags an error
        write_reg(ccl_pkg::CFG_GRID_WIDTH, 3);
        write_reg(ccl_pkg::CFG_GRID_HEIGHT, 2);
        add_word(ccl_pkg::REQ_WRITE, 2, 1, 1'b1);
        add_word(ccl_pkg::REQ_WRITE, 3, 0, 1'b1);
        add_word(ccl_pkg::REQ_QUERY, 3, 0, 1'b0);
        add_word(ccl_pkg::REQ_QUERY, 2, 1, 1'b0);
        wait_drained();

        // zero-sized grid
        write_reg(ccl_pkg::CFG_GRID_WIDTH, 0);
        add_word(ccl_pkg::REQ_WRITE, 0, 0, 1'b1);
        add_word(ccl_pkg::REQ_QUERY, 0, 0, 1'b0);
        wait_drained();

        // oversize values clamp; stored cells outside come back into play
        write_reg(ccl_pkg::CFG_GRID_WIDTH, 127);
        write_reg(ccl_pkg::CFG_GRID_HEIGHT, 127);
        add_word(ccl_pkg::REQ_QUERY, 63, 63, 1'b0);
        wait_drained();

        // unused register indexes are ignored
        write_reg(2'd2, 5);
        write_reg(2'd3, 127);
        add_word(ccl_pkg::REQ_QUERY, 3, 0, 1'b0);
        wait_drained();

        for (int p = 0; p < 12; p++) begin
            case (p % 4)
                0: begin w = $urandom_range(1, 8);  h = $urandom_range(1, 8);  end
                1: begin w = $urandom_range(1, 3);  h = $urandom_range(1, 64); end
                2: begin w = $urandom_range(1, 64); h = $urandom_range(1, 2);  end
                default: begin w = $urandom_range(4, 12); h = $urandom_range(4, 12); end
            endcase
            if (p == 5) w = 0;
            if (p == 9) h = 64 + $urandom_range(1, 63);
            if (p == 11) begin
                quiet = 1'b1;
                w = $urandom_range(1, 8);
                h = $urandom_range(1, 8);
            end
            write_reg(ccl_pkg::CFG_GRID_WIDTH, w);
            write_reg(ccl_pkg::CFG_GRID_HEIGHT, h);
            random_phase(p == 5 ? 40 : PHASE_WORDS);
        end

        wait_drained();
        if (mismatches == 0)
            $display("connected_component_labeler_core regression: pass");
        else
            $display("connected_component_labeler_core regression: fail");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/ccl_pkg.sv
hdl/ccl_ram.sv
hdl/connected_component_labeler_core.sv
sim/tb_connected_component_labeler_core.sv
